/* src/hid_keyboard_report_to_key_events_macros.svh */
// ----------------------------------------------------------------------------
// HID keyboard report decoder assertion macros
// Concurrent assertion wrappers used by the decoder top level. They expand to
// nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef HID_KEYBOARD_REPORT_TO_KEY_EVENTS_MACROS_SVH
`define HID_KEYBOARD_REPORT_TO_KEY_EVENTS_MACROS_SVH
`ifndef SYNTH
// Consequent must hold in the same cycle as the antecedent.
`define HKR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
// Consequent must hold in the cycle after the antecedent.
`define HKR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define HKR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define HKR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

/* src/hkr_pkg.sv */
// ----------------------------------------------------------------------------
// HID keyboard report decoder package
// Constants, types and the usage table lookup shared by the decoder modules.
// ----------------------------------------------------------------------------
package hkr_pkg;

    localparam int HKR_KEY_SLOTS   = 6;
    localparam int HKR_MOD_BITS    = 8;
    localparam int HKR_EVENTS      = HKR_MOD_BITS + 2 * HKR_KEY_SLOTS;
    localparam int HKR_QUEUE_DEPTH = 2;

    localparam logic [7:0] HKR_MOD_BASE = 8'hE0;

    typedef logic [7:0]                              t_usage;
    typedef logic [HKR_KEY_SLOTS-1:0][7:0]           t_key_arr;
    typedef logic [HKR_EVENTS-1:0]                   t_event_mask;

    // One classified report: which events fire and the data they need.
    // Bits 0..7 of the mask are modifier changes, the next six are releases
    // of the previous slots and the last six are presses of the new slots.
    typedef struct packed {
        t_event_mask mask;
        logic [7:0]  mods;
        t_key_arr    prev_keys;
        t_key_arr    keys;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    typedef struct packed {
        logic busy;
    } t_back_status;

    // True for usages that have an entry in the key table.
    function automatic logic usage_known(input t_usage u);
        logic known;
        known = ((u >= 8'h04) && (u <= 8'h81)) ||
                ((u >= 8'h85) && (u <= 8'h8C)) ||
                ((u >= 8'h90) && (u <= 8'h94)) ||
                ((u >= 8'hE0) && (u <= 8'hFB));
        return known;
    endfunction

endpackage

/* src/hkr_if.sv */
// ----------------------------------------------------------------------------
// HID keyboard report decoder channels
// Valid/ready interfaces for incoming reports and outgoing key events.
// ----------------------------------------------------------------------------
interface hkr_report_if;
    logic       valid;
    logic       ready;
    logic [7:0] modifier_bits;
    logic [7:0] slot_key_0;
    logic [7:0] slot_key_1;
    logic [7:0] slot_key_2;
    logic [7:0] slot_key_3;
    logic [7:0] slot_key_4;
    logic [7:0] slot_key_5;

    modport source (
        output valid, modifier_bits, slot_key_0, slot_key_1, slot_key_2,
               slot_key_3, slot_key_4, slot_key_5,
        input  ready
    );
    modport sink (
        input  valid, modifier_bits, slot_key_0, slot_key_1, slot_key_2,
               slot_key_3, slot_key_4, slot_key_5,
        output ready
    );
endinterface

interface hkr_event_if;
    logic       valid;
    logic       ready;
    logic [7:0] usage_code;
    logic       is_pressed;
    logic       last_event;

    modport source (
        output valid, usage_code, is_pressed, last_event,
        input  ready
    );
    modport sink (
        input  valid, usage_code, is_pressed, last_event,
        output ready
    );
endinterface

/* src/hkr_front.sv */
// ----------------------------------------------------------------------------
// HID keyboard report classifier
// Accepts reports, compares them with the stored previous report and pushes
// a mask of the events to emit, with the report data, into the job queue.
// ----------------------------------------------------------------------------
module hkr_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    hkr_report_if.sink            i_report,
    input  hkr_pkg::t_queue_status i_q_status,
    output logic                  o_push,
    output hkr_pkg::t_job         o_job
);
    import hkr_pkg::*;

    logic [7:0]  r_prev_mods;
    t_key_arr    r_prev_keys;
    t_key_arr    keys;
    logic        accept;
    t_event_mask mask;
    logic        alive_prev;
    logic        alive_new;
    logic        found;

    assign keys = {i_report.slot_key_5, i_report.slot_key_4, i_report.slot_key_3,
                   i_report.slot_key_2, i_report.slot_key_1, i_report.slot_key_0};

    assign i_report.ready = !i_q_status.full;
    assign accept         = i_report.valid && i_report.ready;

    // Event mask: modifier changes, then releases, then presses.
    always_comb begin
        mask[HKR_MOD_BITS-1:0] = i_report.modifier_bits ^ r_prev_mods;
        alive_prev = 1'b1;
        alive_new  = 1'b1;
        for (int i = 0; i < HKR_KEY_SLOTS; i++) begin
            // A scan stops at the first empty slot.
            alive_prev = alive_prev && (r_prev_keys[i] != 8'h00);
            found = 1'b0;
            for (int j = 0; j < HKR_KEY_SLOTS; j++) begin
                found = found || (keys[j] == r_prev_keys[i]);
            end
            mask[HKR_MOD_BITS + i] = alive_prev && !found && usage_known(r_prev_keys[i]);

            alive_new = alive_new && (keys[i] != 8'h00);
            found = 1'b0;
            for (int j = 0; j < HKR_KEY_SLOTS; j++) begin
                found = found || (r_prev_keys[j] == keys[i]);
            end
            mask[HKR_MOD_BITS + HKR_KEY_SLOTS + i] = alive_new && !found &&
                                                     usage_known(keys[i]);
        end
    end

    // Reports that change nothing are dropped here.
    assign o_push         = accept && (mask != '0);
    assign o_job.mask      = mask;
    assign o_job.mods      = i_report.modifier_bits;
    assign o_job.prev_keys = r_prev_keys;
    assign o_job.keys      = keys;

    // Stored previous report.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_mods <= '0;
            r_prev_keys <= '0;
        end else if (accept) begin
            r_prev_mods <= i_report.modifier_bits;
            r_prev_keys <= keys;
        end
    end

endmodule

/* src/hkr_queue.sv */
// ----------------------------------------------------------------------------
// HID keyboard report job queue
// Small first-word-fall-through queue between the classifier and the
// event sequencer.
// ----------------------------------------------------------------------------
module hkr_queue #(
    parameter int DEPTH = hkr_pkg::HKR_QUEUE_DEPTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  hkr_pkg::t_job          i_job,
    input  logic                   i_pop,
    output hkr_pkg::t_job          o_job,
    output hkr_pkg::t_queue_status o_status
);
    import hkr_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_entry [DEPTH];
    logic [PW-1:0] r_wptr;
    logic [PW-1:0] r_rptr;
    logic [CW-1:0] r_count;
    logic          do_push;
    logic          do_pop;

    assign o_status.full  = (r_count == CW'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_job          = r_entry[r_rptr];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wptr] <= i_job;
        end
    end

endmodule

/* src/hkr_back.sv */
// ----------------------------------------------------------------------------
// HID keyboard key event sequencer
// Takes classified reports from the queue and emits their events one per cycle
// when the sink is ready, lowest mask bit first, via a registered output stage.
// ----------------------------------------------------------------------------
module hkr_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  hkr_pkg::t_job         i_job,
    input  hkr_pkg::t_queue_status i_q_status,
    output logic                  o_pop,
    output hkr_pkg::t_back_status o_status,
    hkr_event_if.source           o_event
);
    import hkr_pkg::*;

    t_event_mask r_rem;
    t_job        r_job;
    logic        r_out_valid;
    t_usage      r_usage;
    logic        r_pressed;
    logic        r_last;
    t_event_mask n_rem;
    logic        emit;
    logic        last;
    t_usage      sel_usage;
    logic        sel_pressed;

    assign emit = (r_rem != '0) && (!r_out_valid || o_event.ready);
    assign n_rem = r_rem & (r_rem - 1'b1);
    assign last  = (n_rem == '0);
    assign o_pop = !i_q_status.empty && ((r_rem == '0) || (emit && last));

    assign o_status.busy = (r_rem != '0);

    // Pick the lowest pending event and its usage.
    always_comb begin
        sel_usage   = '0;
        sel_pressed = 1'b0;
        for (int i = HKR_EVENTS - 1; i >= 0; i--) begin
            if (r_rem[i]) begin
                if (i < HKR_MOD_BITS) begin
                    sel_usage   = HKR_MOD_BASE + 8'(i);
                    sel_pressed = r_job.mods[i];
                end else if (i < HKR_MOD_BITS + HKR_KEY_SLOTS) begin
                    sel_usage   = r_job.prev_keys[i - HKR_MOD_BITS];
                    sel_pressed = 1'b0;
                end else begin
                    sel_usage   = r_job.keys[i - HKR_MOD_BITS - HKR_KEY_SLOTS];
                    sel_pressed = 1'b1;
                end
            end
        end
    end

    // Pending event mask of the current report.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= '0;
        end else if (o_pop) begin
            r_rem <= i_job.mask;
        end else if (emit) begin
            r_rem <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (o_event.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_usage   <= sel_usage;
            r_pressed <= sel_pressed;
            r_last    <= last;
        end
    end

    assign o_event.valid      = r_out_valid;
    assign o_event.usage_code = r_usage;
    assign o_event.is_pressed = r_pressed;
    assign o_event.last_event = r_last;

endmodule

/* src/hid_keyboard_report_to_key_events.sv */
// ----------------------------------------------------------------------------
// HID boot keyboard report to key events
// Turns boot-protocol keyboard reports into a stream of key press and
// release events.
// ----------------------------------------------------------------------------
// A report is accepted whenever the job queue has room. Each report yields
// first the changed modifier bits (usage 0xE0 plus bit), then releases of
// keys that left, then presses of new keys, with last_event marking the
// final one; a report that changes nothing yields no event. The event
// sequencer emits one event per cycle while the output is ready, so a
// report keeps it busy until all its events (1 to 20) are out, and its
// first event passes through the queue, the pending mask and the output
// register. QUEUE_DEPTH reports can wait in the queue while the sequencer
// works, so reports keep being taken at one per cycle until it fills.
`include "hid_keyboard_report_to_key_events_macros.svh"

module hid_keyboard_report_to_key_events #(
    parameter int QUEUE_DEPTH = hkr_pkg::HKR_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hkr_report_if.sink  i_report,
    hkr_event_if.source o_event
);
    import hkr_pkg::*;

    logic          q_push;
    logic          q_pop;
    t_job          push_job;
    t_job          head_job;
    t_queue_status q_status;
    t_back_status  back_status;

    hkr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_report   (i_report),
        .i_q_status (q_status),
        .o_push     (q_push),
        .o_job      (push_job)
    );

    hkr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_job    (push_job),
        .i_pop    (q_pop),
        .o_job    (head_job),
        .o_status (q_status)
    );

    hkr_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job      (head_job),
        .i_q_status (q_status),
        .o_pop      (q_pop),
        .o_status   (back_status),
        .o_event    (o_event)
    );

    // The classifier never pushes into a full queue.
    `HKR_ASSERT_SAME(a_push_not_full, i_clk, i_rst_n, q_push, !q_status.full, "push into full queue")

    // A pushed job is visible to the sequencer in the next cycle.
    `HKR_ASSERT_NEXT(a_push_visible, i_clk, i_rst_n, q_push, !q_status.empty, "pushed job lost")

    // After a transaction that is not the last of its report, events remain.
    `HKR_ASSERT_SAME(a_report_continues, i_clk, i_rst_n, o_event.valid && o_event.ready && !o_event.last_event, back_status.busy, "report ended without last event")

endmodule
